[sv/tsa_pkg.sv]
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared widths, register codes and types for the 3d swizzle address block.
// ----------------------------------------------------------------------------
package tsa_pkg;

    // payload widths
    localparam int X_W        = 12;
    localparam int Y_W        = 12;
    localparam int Z_W        = 8;
    localparam int SWZ_W      = 36;
    localparam int LIN_W      = 40;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int WIDTH_W    = 13;
    localparam int HEIGHT_W   = 13;
    localparam int DEPTH_W    = 9;
    localparam int PB_W       = 5;
    localparam int LPITCH_W   = 16;
    localparam int PPITCH_W   = 32;

    // interleave bookkeeping: bit counts are at most 12, 12 and 8 with the default caps
    localparam int CNT_W      = 4;
    localparam int IDX_W      = 35;
    localparam int POS_W      = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEX_WIDTH   = 3'd0,
        REG_TEX_HEIGHT  = 3'd1,
        REG_TEX_DEPTH   = 3'd2,
        REG_PIXEL_BYTES = 3'd3,
        REG_LINE_PITCH  = 3'd4,
        REG_PLANE_PITCH = 3'd5
    } t_cfg_reg;

    // settings as seen by the datapath
    typedef struct packed {
        logic [CNT_W-1:0]    nx;
        logic [CNT_W-1:0]    ny;
        logic [CNT_W-1:0]    nz;
        logic [PB_W-1:0]     pixel_bytes;
        logic [LPITCH_W-1:0] line_pitch;
        logic [PPITCH_W-1:0] plane_pitch;
    } t_cfg;

endpackage

[sv/tsa_cfg_if.sv]
// ----------------------------------------------------------------------------
// tsa_cfg_if
// Register write channel: index and data under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tsa_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tsa_pkg::CFG_IDX_W-1:0]  index;
    logic [tsa_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/tsa_coord_if.sv]
// ----------------------------------------------------------------------------
// tsa_coord_if
// Texel coordinate channel.
// ----------------------------------------------------------------------------
interface tsa_coord_if;
    logic                    valid;
    logic                    ready;
    logic [tsa_pkg::X_W-1:0] coord_x;
    logic [tsa_pkg::Y_W-1:0] coord_y;
    logic [tsa_pkg::Z_W-1:0] coord_z;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    output ready);
endinterface

[sv/tsa_offset_if.sv]
// ----------------------------------------------------------------------------
// tsa_offset_if
// Result channel: swizzled and linear byte offsets of one texel.
// ----------------------------------------------------------------------------
interface tsa_offset_if;
    logic                      valid;
    logic                      ready;
    logic [tsa_pkg::SWZ_W-1:0] swizzled_offset;
    logic [tsa_pkg::LIN_W-1:0] linear_offset;

    modport source (output valid, output swizzled_offset, output linear_offset,
                    input ready);
    modport sink   (input valid, input swizzled_offset, input linear_offset,
                    output ready);
endinterface

[sv/texture_swizzle_address_top.sv]
// ----------------------------------------------------------------------------
// texture_swizzle_address_top
// 3d z-order texture address generator: swizzled and pitched linear offsets.
// ----------------------------------------------------------------------------
// Takes one texel coordinate per cycle while the output is not stalled, and
// returns one word holding its swizzled and linear byte offsets. An accepted
// coordinate goes into one input register stage; then the bit interleave,
// the pixel size multiply and the three pitch products with their sum run
// in one pass into the result register. Both stages advance whenever the
// result is taken or the output is empty, so back to back items run at one
// per cycle. While a result waits, the input stage still takes one more
// word if it is empty, and then holds the input until the result is taken.
// Settings writes are taken at any time, but only while no item is in flight
// do they give defined results.
module texture_swizzle_address_top #(
    parameter int MAX_SIZE_LOG2  = 12,
    parameter int MAX_DEPTH_LOG2 = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tsa_cfg_if.sink     i_cfg,
    tsa_coord_if.sink   i_coord,
    tsa_offset_if.source o_offset
);
    import tsa_pkg::*;

    t_cfg cfg;

    logic               r_s1_valid;
    logic [X_W-1:0]     r_x;
    logic [Y_W-1:0]     r_y;
    logic [Z_W-1:0]     r_z;
    logic               r_out_valid;
    logic [SWZ_W-1:0]   r_swz;
    logic [LIN_W-1:0]   r_lin;

    logic               s2_adv;
    logic               s1_adv;
    logic [IDX_W-1:0]   n_idx;
    logic [SWZ_W-1:0]   n_swz;
    logic [LIN_W-1:0]   n_lin;

    function automatic logic [POS_W-1:0] cmin(input int r, input logic [CNT_W-1:0] n);
        logic [POS_W-1:0] rv;
        rv = POS_W'(r);
        return (rv < POS_W'(n)) ? rv : POS_W'(n);
    endfunction

    // settings registers
    tsa_cfg #(
        .MAX_SIZE_LOG2  (MAX_SIZE_LOG2),
        .MAX_DEPTH_LOG2 (MAX_DEPTH_LOG2)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // pipeline flow control
    assign s2_adv        = !r_out_valid || o_offset.ready;
    assign s1_adv        = !r_s1_valid || s2_adv;
    assign i_coord.ready = s1_adv;

    // bit interleave: each coordinate bit lands after every earlier round
    always_comb begin
        logic [POS_W-1:0] pos;
        n_idx = '0;
        for (int r = 0; r < X_W; r++) begin
            pos = POS_W'(r) + cmin(r, cfg.ny) + cmin(r, cfg.nz);
            if (POS_W'(r) < POS_W'(cfg.nx)) begin
                n_idx[pos] = r_x[r];
            end
        end
        for (int r = 0; r < Y_W; r++) begin
            pos = cmin(r + 1, cfg.nx) + POS_W'(r) + cmin(r, cfg.nz);
            if (POS_W'(r) < POS_W'(cfg.ny)) begin
                n_idx[pos] = r_y[r];
            end
        end
        for (int r = 0; r < Z_W; r++) begin
            pos = cmin(r + 1, cfg.nx) + cmin(r + 1, cfg.ny) + POS_W'(r);
            if (POS_W'(r) < POS_W'(cfg.nz)) begin
                n_idx[pos] = r_z[r];
            end
        end
    end

    // offset arithmetic, wrapped to the field widths
    always_comb begin
        logic [LIN_W-1:0] swz_full;
        swz_full = LIN_W'(n_idx) * LIN_W'(cfg.pixel_bytes);
        n_swz    = swz_full[SWZ_W-1:0];
        n_lin    = LIN_W'(r_z) * LIN_W'(cfg.plane_pitch)
                 + LIN_W'(r_y) * LIN_W'(cfg.line_pitch)
                 + LIN_W'(r_x) * LIN_W'(cfg.pixel_bytes);
    end

    // input and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= i_coord.valid;
            end
            if (s2_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
        if (s1_adv && i_coord.valid) begin
            r_x <= i_coord.coord_x;
            r_y <= i_coord.coord_y;
            r_z <= i_coord.coord_z;
        end
        if (s2_adv && r_s1_valid) begin
            r_swz <= n_swz;
            r_lin <= n_lin;
        end
    end

    assign o_offset.valid           = r_out_valid;
    assign o_offset.swizzled_offset = r_swz;
    assign o_offset.linear_offset   = r_lin;

`ifndef ASSERT_OFF
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_coord.valid && i_coord.ready) |=> r_s1_valid)
        else $error("accepted item not held in input stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_adv) |=> (r_s1_valid && $stable(r_x) && $stable(r_z)))
        else $error("stalled input stage lost its item");

    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("result appeared without an item in the input stage");

    a_counts_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(cfg.nx) <= MAX_SIZE_LOG2) && (int'(cfg.ny) <= MAX_SIZE_LOG2)
        && (int'(cfg.nz) <= MAX_DEPTH_LOG2))
        else $error("interleave bit count above its cap");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_s1_valid))
        else $error("pipeline not empty after reset");
`endif

endmodule

[sv/tsa_cfg.sv]
// ----------------------------------------------------------------------------
// tsa_cfg
// Settings registers. Texture sizes are turned into interleave bit counts
// at write time, so the datapath only sees the capped counts.
// ----------------------------------------------------------------------------
module tsa_cfg #(
    parameter int MAX_SIZE_LOG2  = 12,
    parameter int MAX_DEPTH_LOG2 = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tsa_cfg_if.sink       i_cfg,
    output tsa_pkg::t_cfg o_cfg
);
    import tsa_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // ceil(log2(size)) capped at cap; sizes zero and one give no bits
    function automatic logic [CNT_W-1:0] bit_count(input logic [WIDTH_W-1:0] size,
                                                   input int cap);
        logic [WIDTH_W-1:0] sm1;
        int                 n;
        sm1 = size - WIDTH_W'(1);
        n   = 0;
        if (size > WIDTH_W'(1)) begin
            for (int i = 0; i < WIDTH_W; i++) begin
                if (sm1[i]) begin
                    n = i + 1;
                end
            end
        end
        if (n > cap) begin
            n = cap;
        end
        return CNT_W'(n);
    endfunction

    assign i_cfg.ready = 1'b1;

    // register decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_TEX_WIDTH: begin
                    n_cfg.nx = bit_count(i_cfg.data[WIDTH_W-1:0], MAX_SIZE_LOG2);
                end
                REG_TEX_HEIGHT: begin
                    n_cfg.ny = bit_count(i_cfg.data[HEIGHT_W-1:0], MAX_SIZE_LOG2);
                end
                REG_TEX_DEPTH: begin
                    n_cfg.nz = bit_count(WIDTH_W'(i_cfg.data[DEPTH_W-1:0]),
                                         MAX_DEPTH_LOG2);
                end
                REG_PIXEL_BYTES: begin
                    n_cfg.pixel_bytes = i_cfg.data[PB_W-1:0];
                end
                REG_LINE_PITCH: begin
                    n_cfg.line_pitch = i_cfg.data[LPITCH_W-1:0];
                end
                REG_PLANE_PITCH: begin
                    n_cfg.plane_pitch = i_cfg.data[PPITCH_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    // sizes reset to one texel, four bytes per texel, zero pitches
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nx          <= '0;
            r_cfg.ny          <= '0;
            r_cfg.nz          <= '0;
            r_cfg.pixel_bytes <= PB_W'(4);
            r_cfg.line_pitch  <= '0;
            r_cfg.plane_pitch <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
